/* src/sec_pkg.sv */
package sec_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 24;
  localparam int ITER_BITS = 16;
  localparam int TOP_W     = 6;                  // index of a bit in a 64-bit word
  localparam int LOG_STEPS = 32;                 // fraction bits of each log2
  localparam int L_W       = TOP_W + LOG_STEPS;  // width of log2(|z|^2)
  localparam int DIV_STEPS = 10;                 // quotient bits below saturation
  localparam int V_W       = 10;
  localparam int PIX_W     = 27;

  localparam logic [63:0]      MAG_ONE   = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0]      SMOOTH_K  = 64'd6565998574;
  localparam logic [V_W-1:0]   V_MAX     = 10'd1023;

  // Configuration register indexes and reset values
  localparam logic REG_MAX_ITER   = 1'b0;
  localparam logic REG_COLOR_MODE = 1'b1;
  localparam logic [15:0] MAX_ITER_RST = 16'd64;

  typedef enum logic [2:0] {
    MODE_RED_BLUE     = 3'd0,
    MODE_RED          = 3'd1,
    MODE_GREEN        = 3'd2,
    MODE_BLUE         = 3'd3,
    MODE_RED_GREEN    = 3'd4,
    MODE_GREY         = 3'd5,
    MODE_GREEN_BLUE   = 3'd6,
    MODE_RED_BLUE_ALT = 3'd7
  } color_mode_e;

  // Per-word sideband that travels down the pipeline
  typedef struct packed {
    logic                 blank;  // force color 0
    logic                 sat;    // force full-scale value
    logic [ITER_BITS-1:0] count;
  } side_t;

endpackage

/* src/sec_log2.sv */
module sec_log2 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [63:0]          value_i,
  input  sec_pkg::side_t       side_i,
  output logic                 valid_o,
  output logic [31:0]          frac_o,
  output logic [5:0]           top_o,
  output sec_pkg::side_t       side_o
);
  import sec_pkg::*;

  logic                    a_valid_q;
  logic [63:0]             a_value_q;
  logic [TOP_W-1:0]        a_top_q;
  logic [TOP_W-1:0]        top_d;
  side_t                   a_side_q;

  logic                    valid_q [LOG_STEPS+1];
  logic [31:0]             x_q     [LOG_STEPS+1];
  logic [LOG_STEPS-1:0]    frac_q  [LOG_STEPS+1];
  logic [TOP_W-1:0]        top_q   [LOG_STEPS+1];
  side_t                   side_q  [LOG_STEPS+1];
  logic [94:0]             wide;

  // Find the top set bit
  always_comb begin
    top_d = '0;
    for (int i = 0; i < 64; i++) begin
      if (value_i[i]) top_d = TOP_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_value_q <= value_i;
      a_top_q   <= top_d;
      a_side_q  <= side_i;
    end
  end

  // Normalize to a Q1.31 mantissa in [1,2)
  assign wide = {a_value_q, 31'd0} >> a_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= wide[31:0];
      frac_q[0] <= '0;
      top_q[0]  <= a_top_q;
      side_q[0] <= a_side_q;
    end
  end

  // One squaring per stage, one fraction bit per stage
  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = x_q[g] * x_q[g];
    assign t  = sq[63:31];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[g+1] <= valid_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]    <= t[32] ? t[32:1] : t[31:0];
        frac_q[g+1] <= {frac_q[g][LOG_STEPS-2:0], t[32]};
        top_q[g+1]  <= top_q[g];
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = valid_q[LOG_STEPS];
  assign frac_o  = frac_q[LOG_STEPS];
  assign top_o   = top_q[LOG_STEPS];
  assign side_o  = side_q[LOG_STEPS];

endmodule

/* src/smooth_escape_color.sv */
// Smooth escape coloring: takes one escaped point per cycle (final z in signed
// Q8.24 and its iteration count) and returns one packed color word per cycle
// while no stall holds the flow. Two 34-stage log2 units set most of the depth:
// top-bit search, normalize, then one mantissa squaring per stage. An 11-stage
// divider by max_iterations follows: a saturation test, then one restoring step
// per quotient bit. Throughput is one word per cycle while not stalled. When the
// output stalls, one more word lands in a skid register and then the input is
// stalled. Write configuration only while idle.
module smooth_escape_color (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    escape_real_i,
  input  logic signed [31:0]    escape_imag_i,
  input  logic [15:0]           iteration_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [26:0]           pixel_color_o
);
  import sec_pkg::*;

  logic [15:0]        max_iter_q;
  color_mode_e        mode_q;
  logic               en;
  logic               skid_v_q;
  logic [PIX_W-1:0]   skid_q;
  logic               out_v_q;
  logic [PIX_W-1:0]   out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
      mode_q     <= MODE_RED;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_ITER:   max_iter_q <= cfg_wdata_i;
        REG_COLOR_MODE: mode_q     <= color_mode_e'(cfg_wdata_i[2:0]);
        default:        max_iter_q <= max_iter_q;
      endcase
    end
  end

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // Stage 1: magnitudes
  logic               s1_v_q;
  logic [31:0]        ar_q, ai_q;
  logic [ITER_BITS-1:0] c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ar_q <= escape_real_i[31] ? (~escape_real_i + 32'd1) : escape_real_i;
      ai_q <= escape_imag_i[31] ? (~escape_imag_i + 32'd1) : escape_imag_i;
      c1_q <= iteration_count_i[ITER_BITS-1:0];
    end
  end

  // Stage 2: squares
  logic               s2_v_q;
  logic [63:0]        sr_q, si_q;
  logic [ITER_BITS-1:0] c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= ar_q * ar_q;
      si_q <= ai_q * ai_q;
      c2_q <= c1_q;
    end
  end

  // Stage 3: |z|^2 and the blank test
  logic               s3_v_q;
  logic [63:0]        m_q;
  side_t              s3_side_q;
  logic [63:0]        m_d;

  assign m_d = sr_q + si_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q             <= m_d;
      s3_side_q.blank <= (c2_q == '0) || (m_d <= MAG_ONE);
      s3_side_q.sat   <= 1'b0;
      s3_side_q.count <= c2_q;
    end
  end

  // First log2: log2(|z|^2)
  logic               la_v;
  logic [31:0]        la_frac;
  logic [5:0]         la_top;
  side_t              la_side;

  sec_log2 u_log_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .value_i (m_q),
    .side_i  (s3_side_q),
    .valid_o (la_v),
    .frac_o  (la_frac),
    .top_o   (la_top),
    .side_o  (la_side)
  );

  // Stage 4: L in Q.32, flag a vanishing log
  logic               s4_v_q;
  logic [L_W-1:0]     l_q;
  side_t              s4_side_q;
  logic [L_W-1:0]     l_d;

  assign l_d = {la_top - TOP_W'(2 * FRAC_BITS), la_frac};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= la_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q             <= l_d;
      s4_side_q.blank <= la_side.blank;
      s4_side_q.sat   <= (l_d == '0);
      s4_side_q.count <= la_side.count;
    end
  end

  // Second log2: log2(L)
  logic               lb_v;
  logic [31:0]        lb_frac;
  logic [5:0]         lb_top;
  side_t              lb_side;

  sec_log2 u_log_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .value_i (64'(l_q)),
    .side_i  (s4_side_q),
    .valid_o (lb_v),
    .frac_o  (lb_frac),
    .top_o   (lb_top),
    .side_o  (lb_side)
  );

  // Stage 5: smooth count s in signed Q.32
  logic               s5_v_q;
  logic [63:0]        s_q;
  side_t              s5_side_q;
  logic signed [24:0] s_hi;
  logic [63:0]        s_d;

  assign s_hi = $signed({9'd0, lb_side.count}) - $signed({19'd0, lb_top}) + 25'sd32;
  assign s_d  = ({{39{s_hi[24]}}, s_hi} << 32) - {32'd0, lb_frac} + SMOOTH_K;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= lb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q       <= s_d;
      s5_side_q <= lb_side;
    end
  end

  // Stage 6: scale by 767, drop 32 fraction bits
  logic               s6_v_q;
  logic [31:0]        d_q;
  side_t              s6_side_q;
  logic               pos;
  logic [63:0]        prod;

  assign pos  = !s_q[63] && (s_q != '0);
  assign prod = (s_q << 9) + (s_q << 8) - s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q             <= prod[63:32];
      s6_side_q.blank <= s5_side_q.blank || (!pos && !s5_side_q.sat);
      s6_side_q.sat   <= s5_side_q.sat;
      s6_side_q.count <= s5_side_q.count;
    end
  end

  // Divider: saturation test, then one quotient bit per stage
  logic [15:0]          dv;
  logic                 dv_v_q   [DIV_STEPS+1];
  logic [31:0]          rem_q    [DIV_STEPS+1];
  logic [V_W-1:0]       quo_q    [DIV_STEPS+1];
  side_t                dv_side_q[DIV_STEPS+1];

  assign dv = (max_iter_q == '0) ? 16'd1 : max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]           <= d_q;
      quo_q[0]           <= '0;
      dv_side_q[0].blank <= s6_side_q.blank;
      dv_side_q[0].sat   <= s6_side_q.sat || (d_q >= (32'(dv) << DIV_STEPS));
      dv_side_q[0].count <= s6_side_q.count;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [31:0] dsh;
    logic        take;
    assign dsh  = 32'(dv) << B;
    assign take = rem_q[j] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j+1]     <= take ? (rem_q[j] - dsh) : rem_q[j];
        quo_q[j+1]     <= quo_q[j] | (take ? (V_W'(1) << B) : '0);
        dv_side_q[j+1] <= dv_side_q[j];
      end
    end
  end

  // Pack stage: place the value into the selected channels
  logic               pk_v_q;
  logic [PIX_W-1:0]   pk_q;
  logic [V_W-1:0]     v;
  logic [PIX_W-1:0]   r, g, b;
  side_t              fin;

  assign fin = dv_side_q[DIV_STEPS];
  assign v   = fin.blank ? '0 : (fin.sat ? V_MAX : quo_q[DIV_STEPS]);

  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    case (mode_q)
      MODE_RED:        r = PIX_W'(v);
      MODE_GREEN:      g = PIX_W'(v);
      MODE_BLUE:       b = PIX_W'(v);
      MODE_RED_GREEN: begin
        r = PIX_W'(v);
        g = PIX_W'(v);
      end
      MODE_GREY: begin
        r = PIX_W'(v);
        g = PIX_W'(v);
        b = PIX_W'(v);
      end
      MODE_GREEN_BLUE: begin
        g = PIX_W'(v);
        b = PIX_W'(v);
      end
      default: begin
        r = PIX_W'(v);
        b = PIX_W'(v);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_v_q <= 1'b0;
    end else if (en) begin
      pk_v_q <= dv_v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_q <= (r << 16) + (g << 8) + b;
    end
  end

  // Output register with skid: hold while stalled, park one word in the skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= pk_v_q;
      end
    end else if (en && pk_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : pk_q;
    end else if (en && pk_v_q) begin
      skid_q <= pk_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign pixel_color_o = out_q;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held without an output word");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> !skid_v_q)
    else $error("skid word not drained after output was taken");

  a_red_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (mode_q == MODE_RED) && $stable(mode_q) |-> (out_q[15:0] == '0))
    else $error("red mode produced green or blue bits");

endmodule
